### rtl/core/ders_pkg.sv
// ----------------------------------------------------------------------------
// ders_pkg
// Shared types and constants for the distance error running statistics block.
// ----------------------------------------------------------------------------
package ders_pkg;

    localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR    = 2'd1;
    localparam logic [1:0] FUNC_DISABLE  = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam int SUM_W = 64;
    localparam int CNT_OUT_W = 24;
    localparam int VAL_OUT_W = 25;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,      // act on the latched transaction: clear or disable as needed
        OP_SQ,        // form dx*dx + dy*dy
        OP_SQRT_E,    // one step of the error square root
        OP_DIFF,      // |e - mean|, bump count
        OP_DIV_M,     // one step of a / n
        OP_MEAN,      // new mean, b
        OP_MUL,       // one partial product of a*b
        OP_ACC,       // saturating add into the sum
        OP_DIV_V,     // one step of sum / (n-1)
        OP_SQRT_V,    // one step of the deviation square root
        OP_OUT        // load the result register
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] step;
    } ctl_cmd_t;

    typedef struct packed {
        logic sample;    // loaded transaction captures a sample
        logic cnt_gt1;   // count above one
    } dp_stat_t;

endpackage

### rtl/core/ders_ctrl.sv
// ----------------------------------------------------------------------------
// ders_ctrl
// Sequencer: walks the datapath through the sample update and the readout.
// ----------------------------------------------------------------------------
module ders_ctrl #(
    parameter int ERR_STEPS  = 40,
    parameter int MEAN_STEPS = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  ders_pkg::dp_stat_t  stat,
    output ders_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOAD, ST_SQ, ST_SQRTE, ST_DIFF, ST_DIVM, ST_MEAN,
        ST_MUL, ST_ACC, ST_DIVV, ST_SQRTV, ST_OUT
    } state_t;

    state_t     state_reg;
    logic [6:0] step_reg;
    logic       m_valid_reg;
    logic       out_load;

    // result register free, or emptied this cycle
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd.step = step_reg;
        case (state_reg)
            ST_LOAD:  cmd.op = ders_pkg::OP_LOAD;
            ST_SQ:    cmd.op = ders_pkg::OP_SQ;
            ST_SQRTE: cmd.op = ders_pkg::OP_SQRT_E;
            ST_DIFF:  cmd.op = ders_pkg::OP_DIFF;
            ST_DIVM:  cmd.op = ders_pkg::OP_DIV_M;
            ST_MEAN:  cmd.op = ders_pkg::OP_MEAN;
            ST_MUL:   cmd.op = ders_pkg::OP_MUL;
            ST_ACC:   cmd.op = ders_pkg::OP_ACC;
            ST_DIVV:  cmd.op = ders_pkg::OP_DIV_V;
            ST_SQRTV: cmd.op = ders_pkg::OP_SQRT_V;
            ST_OUT:   cmd.op = out_load ? ders_pkg::OP_OUT : ders_pkg::OP_NONE;
            default:  cmd.op = ders_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_valid && s_ready) state_reg <= ST_LOAD;
                ST_LOAD: begin
                    step_reg  <= '0;
                    state_reg <= stat.sample ? ST_SQ : ST_DIVV;
                end
                ST_SQ: state_reg <= ST_SQRTE;
                ST_SQRTE: begin
                    if (step_reg == 7'(ERR_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_DIFF;
                    end else step_reg <= step_reg + 7'd1;
                end
                ST_DIFF: state_reg <= ST_DIVM;
                ST_DIVM: begin
                    if (step_reg == 7'(MEAN_STEPS - 1)) begin
                        step_reg  <= '0;
                        state_reg <= ST_MEAN;
                    end else step_reg <= step_reg + 7'd1;
                end
                ST_MEAN: state_reg <= ST_MUL;
                ST_MUL: begin
                    if (step_reg == 7'd1) begin
                        step_reg  <= '0;
                        state_reg <= ST_ACC;
                    end else step_reg <= step_reg + 7'd1;
                end
                ST_ACC: state_reg <= ST_DIVV;
                ST_DIVV: begin
                    if (!stat.cnt_gt1) begin
                        state_reg <= ST_OUT;
                    end else if (step_reg == 7'd63) begin
                        step_reg  <= '0;
                        state_reg <= ST_SQRTV;
                    end else step_reg <= step_reg + 7'd1;
                end
                ST_SQRTV: begin
                    if (step_reg == 7'd31) begin
                        step_reg  <= '0;
                        state_reg <= ST_OUT;
                    end else step_reg <= step_reg + 7'd1;
                end
                ST_OUT: if (out_load) state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready) else $error("ready while busy");
    a_out_after: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT) else $error("stray result");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg) else $error("result dropped");
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg < 7'(ERR_STEPS + 64)) else $error("step overrun");

endmodule

### rtl/core/ders_dp.sv
// ----------------------------------------------------------------------------
// ders_dp
// Datapath: statistics registers, a shared restoring root/divide step,
// and a split saturating multiply.
// ----------------------------------------------------------------------------
module ders_dp #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic [1:0]                   s_func,
    input  logic signed [15:0]           s_cur_x,
    input  logic signed [15:0]           s_cur_y,
    input  logic signed [15:0]           s_tgt_x,
    input  logic signed [15:0]           s_tgt_y,
    input  logic                         s_moving,
    input  ders_pkg::ctl_cmd_t           cmd,
    output ders_pkg::dp_stat_t           stat,
    output logic [ders_pkg::CNT_OUT_W-1:0] m_sample_count,
    output logic [ders_pkg::VAL_OUT_W-1:0] m_mean_error,
    output logic [ders_pkg::VAL_OUT_W-1:0] m_std_dev,
    output logic                         m_captured
);
    localparam int MW = 17 + FRAC_BITS;     // mean / error width
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic                  capture_on_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [MW-1:0]         mean_reg;
    logic [63:0]           sq_dev_sum_reg;

    logic [1:0]  func_reg;
    logic        moving_reg, took_reg;
    logic [16:0] ax_reg, ay_reg;
    logic [63:0] v_reg;        // radicand / dividend shifting
    logic [63:0] q_reg;        // quotient / root
    logic [65:0] r_reg;        // partial remainder
    logic [MW-1:0] e_reg, a_reg, b_reg;
    logic        ge_reg;
    logic [63:0] dvsr_reg;
    logic [64:0] prod_reg;
    logic        ovf_reg;

    logic [ders_pkg::CNT_OUT_W-1:0] cnt_out_reg;
    logic [ders_pkg::VAL_OUT_W-1:0] mean_out_reg;
    logic [ders_pkg::VAL_OUT_W-1:0] sd_out_reg;
    logic                           captured_out_reg;

    logic [16:0] dxa, dya;
    logic signed [16:0] dxs, dys;
    assign dxs = 17'(s_cur_x) - 17'(s_tgt_x);
    assign dys = 17'(s_cur_y) - 17'(s_tgt_y);
    assign dxa = dxs[16] ? 17'(-dxs) : 17'(dxs);
    assign dya = dys[16] ? 17'(-dys) : 17'(dys);

    // shared trial-subtract for square root
    logic [65:0] sr_r, sr_t;
    always_comb begin
        sr_r = {r_reg[63:0], v_reg[63:62]};
        sr_t = {q_reg, 2'b01};
    end
    // shared divide step
    logic [64:0] dv_r;
    assign dv_r = {r_reg[63:0], v_reg[63]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capture_on_reg   <= 1'b0;
            count_reg        <= '0;
            mean_reg         <= '0;
            sq_dev_sum_reg   <= '0;
            took_reg         <= 1'b0;
            cnt_out_reg      <= '0;
            mean_out_reg     <= '0;
            sd_out_reg       <= '0;
            captured_out_reg <= 1'b0;
        end else begin
            case (cmd.op)
                ders_pkg::OP_NONE: ;
                ders_pkg::OP_LOAD: begin
                    took_reg <= 1'b0;
                    if (func_reg == ders_pkg::FUNC_CLEAR) begin
                        capture_on_reg <= 1'b1;
                        count_reg      <= '0;
                        mean_reg       <= '0;
                        sq_dev_sum_reg <= '0;
                    end else if (func_reg == ders_pkg::FUNC_DISABLE) begin
                        capture_on_reg <= 1'b0;
                    end
                    q_reg <= '0;
                    r_reg <= '0;
                end
                ders_pkg::OP_SQ: begin
                    v_reg <= 64'(ax_reg * ax_reg) + 64'(ay_reg * ay_reg);
                    q_reg <= '0;
                    r_reg <= '0;
                end
                ders_pkg::OP_SQRT_E, ders_pkg::OP_SQRT_V: begin
                    v_reg <= {v_reg[61:0], 2'b00};
                    if (sr_r >= sr_t) begin
                        r_reg <= sr_r - sr_t;
                        q_reg <= {q_reg[62:0], 1'b1};
                    end else begin
                        r_reg <= sr_r;
                        q_reg <= {q_reg[62:0], 1'b0};
                    end
                end
                ders_pkg::OP_DIFF: begin
                    e_reg <= MW'(q_reg);
                    took_reg <= 1'b1;
                    if (count_reg != CNT_MAX) count_reg <= count_reg + 1'b1;
                    ge_reg <= MW'(q_reg) >= mean_reg;
                    a_reg  <= (MW'(q_reg) >= mean_reg) ? MW'(q_reg) - mean_reg
                                                        : mean_reg - MW'(q_reg);
                    v_reg  <= '0;
                    r_reg  <= '0;
                    q_reg  <= '0;
                end
                ders_pkg::OP_DIV_M: begin
                    // MW quotient bits: top bit here, the rest one per step
                    if (cmd.step == 7'd0) begin
                        dvsr_reg <= 64'(count_reg);
                        v_reg    <= {a_reg << 1, {(64-MW){1'b0}}};
                        if (64'(a_reg[MW-1]) >= 64'(count_reg)) begin
                            r_reg <= 66'(a_reg[MW-1]) - 66'(count_reg);
                            q_reg <= 64'd1;
                        end else begin
                            r_reg <= 66'(a_reg[MW-1]);
                            q_reg <= '0;
                        end
                    end else begin
                        v_reg <= {v_reg[62:0], 1'b0};
                        if (dv_r >= 65'(dvsr_reg)) begin
                            r_reg <= 66'(dv_r - 65'(dvsr_reg));
                            q_reg <= {q_reg[62:0], 1'b1};
                        end else begin
                            r_reg <= 66'(dv_r);
                            q_reg <= {q_reg[62:0], 1'b0};
                        end
                    end
                end
                ders_pkg::OP_MEAN: begin
                    if (ge_reg) begin
                        mean_reg <= mean_reg + MW'(q_reg);
                        b_reg    <= e_reg - (mean_reg + MW'(q_reg));
                    end else begin
                        mean_reg <= mean_reg - MW'(q_reg);
                        b_reg    <= (mean_reg - MW'(q_reg)) - e_reg;
                    end
                end
                ders_pkg::OP_MUL: begin
                    // low 16 bits of a first, then the upper part
                    if (cmd.step == 7'd0) begin
                        prod_reg <= 65'(a_reg[15:0] * b_reg);
                        ovf_reg  <= 1'b0;
                    end else begin
                        {ovf_reg, prod_reg} <= 66'(prod_reg)
                            + (66'(a_reg[MW-1:16] * b_reg) << 16);
                    end
                end
                ders_pkg::OP_ACC: begin
                    if (ovf_reg || prod_reg[64] ||
                        (65'(sq_dev_sum_reg) + 65'(prod_reg[63:0])) > 65'(64'hFFFF_FFFF_FFFF_FFFF))
                        sq_dev_sum_reg <= '1;
                    else
                        sq_dev_sum_reg <= sq_dev_sum_reg + prod_reg[63:0];
                end
                ders_pkg::OP_DIV_V: begin
                    if (cmd.step == 7'd0) begin
                        dvsr_reg <= 64'(count_reg) - 64'd1;
                        v_reg    <= {sq_dev_sum_reg[62:0], 1'b0};
                        if (64'(sq_dev_sum_reg[63]) >= 64'(count_reg) - 64'd1) begin
                            r_reg <= 66'(sq_dev_sum_reg[63]) - 66'(64'(count_reg) - 64'd1);
                            q_reg <= 64'd1;
                        end else begin
                            r_reg <= 66'(sq_dev_sum_reg[63]);
                            q_reg <= '0;
                        end
                    end else if (cmd.step == 7'd63) begin
                        // last bit: hand quotient to the root
                        v_reg <= (dv_r >= 65'(dvsr_reg)) ? {q_reg[62:0], 1'b1}
                                                         : {q_reg[62:0], 1'b0};
                        q_reg <= '0;
                        r_reg <= '0;
                    end else begin
                        v_reg <= {v_reg[62:0], 1'b0};
                        if (dv_r >= 65'(dvsr_reg)) begin
                            r_reg <= 66'(dv_r - 65'(dvsr_reg));
                            q_reg <= {q_reg[62:0], 1'b1};
                        end else begin
                            r_reg <= 66'(dv_r);
                            q_reg <= {q_reg[62:0], 1'b0};
                        end
                    end
                end
                ders_pkg::OP_OUT: begin
                    cnt_out_reg  <= (64'(count_reg) > 64'(24'hFFFFFF)) ? '1
                                  : ders_pkg::CNT_OUT_W'(count_reg);
                    mean_out_reg <= (64'(mean_reg) > 64'(25'h1FFFFFF)) ? '1
                                  : ders_pkg::VAL_OUT_W'(mean_reg);
                    sd_out_reg   <= !stat.cnt_gt1 ? '0
                                  : (q_reg > 64'(25'h1FFFFFF)) ? '1
                                  : ders_pkg::VAL_OUT_W'(q_reg);
                    captured_out_reg <= took_reg;
                end
                default: ;
            endcase
        end
    end

    // error root runs 32 integer steps then FRAC_BITS fraction steps (zeros shift in)
    always_ff @(posedge aclk) begin
        if (load) begin
            func_reg   <= s_func;
            moving_reg <= s_moving;
            ax_reg     <= dxa;
            ay_reg     <= dya;
        end
    end

    assign stat.sample  = (func_reg == ders_pkg::FUNC_SAMPLE) && capture_on_reg && moving_reg;
    assign stat.cnt_gt1 = count_reg > COUNT_BITS'(1);

    assign m_sample_count = cnt_out_reg;
    assign m_mean_error   = mean_out_reg;
    assign m_std_dev      = sd_out_reg;
    assign m_captured     = captured_out_reg;

endmodule

### rtl/core/distance_error_running_stats.sv
// ----------------------------------------------------------------------------
// distance_error_running_stats
// Welford running mean and standard deviation of the distance error.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time; a finished result waits in an output
// register, so the next transaction can be taken while it is held. A command
// or non-capturing sample skips the error root, mean update and multiply. The
// datapath steps work one bit per cycle: error root 32 + FRAC_BITS, mean
// divide 17 + FRAC_BITS, variance divide 64 and deviation root 32. While the
// count is below two the variance divide and root are skipped. s_ready comes
// back at the edge that loads the result register, which waits while that
// register still holds an unaccepted result.
module distance_error_running_stats #(
    parameter int COUNT_BITS = 24,
    parameter int FRAC_BITS  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [15:0] s_cur_x,
    input  logic signed [15:0] s_cur_y,
    input  logic signed [15:0] s_tgt_x,
    input  logic signed [15:0] s_tgt_y,
    input  logic               s_moving,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [23:0]        m_sample_count,
    output logic [24:0]        m_mean_error,
    output logic [24:0]        m_std_dev,
    output logic               m_captured
);
    ders_pkg::ctl_cmd_t cmd;
    ders_pkg::dp_stat_t stat;

    ders_ctrl #(.ERR_STEPS(32 + FRAC_BITS), .MEAN_STEPS(17 + FRAC_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .stat, .cmd
    );

    ders_dp #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk, .aresetn, .load(s_valid && s_ready), .s_func, .s_cur_x, .s_cur_y,
        .s_tgt_x, .s_tgt_y, .s_moving, .cmd, .stat, .m_sample_count,
        .m_mean_error, .m_std_dev, .m_captured
    );
endmodule
